// ----- rtl/fwa_pkg.sv -----
// Package for the writer arbiter: sizes, command codes and the structs that
// pass between the input stage, the queue and the output stage.
// Has no dependencies.
`default_nettype none

package fwa_pkg;

    localparam int WRITER_COUNT = 16;
    localparam int ID_W = 4;
    localparam int PTR_W = (WRITER_COUNT > 1) ? $clog2(WRITER_COUNT) : 1;
    localparam int CNT_W = $clog2(WRITER_COUNT + 1);

    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0] writer_id;
        logic [1:0]      command;
    } item_t;

    typedef struct packed {
        logic empty_release;
        logic present;
        logic granted;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]        entry_count;
        logic [WRITER_COUNT-1:0] waiting_bitmap;
    } queue_status_t;

endpackage

`default_nettype wire

// ----- rtl/fwa_in_reg.sv -----
// Input register stage of the writer arbiter: captures one request and holds
// it until the queue logic consumes it. Depends on fwa_pkg.
`default_nettype none

module fwa_in_reg
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire fwa_pkg::item_t in_item,
    input  wire logic          advance,
    output logic               item_valid,
    output fwa_pkg::item_t     item
);

    logic           valid_reg;
    logic           valid_next;
    fwa_pkg::item_t item_reg;

    assign in_ready = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

`default_nettype wire

// ----- rtl/fwa_queue.sv -----
// Arrival-order queue of writer ids with a presence bitmap, and the decision
// logic for request, release and query. Depends on fwa_pkg.
`default_nettype none

module fwa_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           bypass,
    input  wire logic           fire,
    input  wire fwa_pkg::item_t item,
    output fwa_pkg::result_t    result,
    output fwa_pkg::queue_status_t status
);

    logic [fwa_pkg::ID_W-1:0]         store_reg [fwa_pkg::WRITER_COUNT];
    logic [fwa_pkg::PTR_W-1:0]        head_reg;
    logic [fwa_pkg::PTR_W-1:0]        head_next;
    logic [fwa_pkg::CNT_W-1:0]        count_reg;
    logic [fwa_pkg::CNT_W-1:0]        count_next;
    logic [fwa_pkg::WRITER_COUNT-1:0] bitmap_reg;
    logic [fwa_pkg::WRITER_COUNT-1:0] bitmap_next;

    logic                             valid_id;
    logic [fwa_pkg::WRITER_COUNT-1:0] id_mask;
    logic [fwa_pkg::WRITER_COUNT-1:0] head_mask;
    logic [fwa_pkg::ID_W-1:0]         head_entry;
    logic                             is_waiting;
    logic                             enqueue;
    logic                             dequeue;
    logic [fwa_pkg::CNT_W:0]          tail_sum;
    logic [fwa_pkg::PTR_W-1:0]        tail;

    assign head_entry = store_reg[head_reg];

    always_comb
    begin
        valid_id = (int'(item.writer_id) < fwa_pkg::WRITER_COUNT);
        id_mask = fwa_pkg::WRITER_COUNT'(1) << item.writer_id;
        head_mask = fwa_pkg::WRITER_COUNT'(1) << head_entry;
        is_waiting = valid_id && ((bitmap_reg & id_mask) != '0);
        enqueue = 1'b0;
        dequeue = 1'b0;
        result = '0;

        tail_sum = (fwa_pkg::CNT_W + 1)'(head_reg) + (fwa_pkg::CNT_W + 1)'(count_reg);
        if (tail_sum >= (fwa_pkg::CNT_W + 1)'(fwa_pkg::WRITER_COUNT))
        begin
            tail = fwa_pkg::PTR_W'(tail_sum - (fwa_pkg::CNT_W + 1)'(fwa_pkg::WRITER_COUNT));
        end
        else
        begin
            tail = fwa_pkg::PTR_W'(tail_sum);
        end

        case (item.command)
            fwa_pkg::CMD_REQUEST:
            begin
                if (bypass)
                begin
                    result.granted = 1'b1;
                end
                else if (valid_id)
                begin
                    enqueue = !is_waiting
                              && (count_reg < fwa_pkg::CNT_W'(fwa_pkg::WRITER_COUNT));
                    if (count_reg == '0)
                    begin
                        result.granted = enqueue;
                    end
                    else
                    begin
                        result.granted = (head_entry == item.writer_id);
                    end
                end
            end
            fwa_pkg::CMD_RELEASE:
            begin
                if (!bypass)
                begin
                    if (count_reg == '0)
                    begin
                        result.empty_release = 1'b1;
                    end
                    else
                    begin
                        dequeue = 1'b1;
                    end
                end
            end
            fwa_pkg::CMD_QUERY:
            begin
                result.present = !bypass && is_waiting;
            end
            default:
            begin
                result = '0;
            end
        endcase

        head_next = head_reg;
        count_next = count_reg;
        bitmap_next = bitmap_reg;
        if (fire && enqueue)
        begin
            count_next = count_reg + fwa_pkg::CNT_W'(1);
            bitmap_next = bitmap_reg | id_mask;
        end
        if (fire && dequeue)
        begin
            count_next = count_reg - fwa_pkg::CNT_W'(1);
            bitmap_next = bitmap_reg & ~head_mask;
            if (head_reg == fwa_pkg::PTR_W'(fwa_pkg::WRITER_COUNT - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + fwa_pkg::PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            count_reg <= '0;
            bitmap_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            count_reg <= count_next;
            bitmap_reg <= bitmap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && enqueue)
        begin
            store_reg[tail] <= item.writer_id;
        end
    end

    assign status.entry_count = count_reg;
    assign status.waiting_bitmap = bitmap_reg;

endmodule

`default_nettype wire

// ----- rtl/fwa_out_reg.sv -----
// Result register of the writer arbiter: holds one response until the
// downstream side takes it. Depends on fwa_pkg.
`default_nettype none

module fwa_out_reg
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire fwa_pkg::result_t load_result,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output fwa_pkg::result_t      out_result,
    output logic                  advance
);

    logic             valid_reg;
    logic             valid_next;
    fwa_pkg::result_t result_reg;

    assign advance = !valid_reg || out_ready;
    assign valid_next = advance ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/fifo_writer_arbiter_top.sv -----
// Writer arbiter top level: an accepted request is held in the input register,
// and its response in the result register, before it appears on the output.
// Throughput is one request per cycle while the output is not back-pressured,
// set by the single queue update per cycle. Reset clears the queue head pointer,
// count, bitmap and bypass flag at once; the order store is not cleared.
// Depends on fwa_pkg, fwa_in_reg, fwa_queue and fwa_out_reg.
`default_nettype none

module fifo_writer_arbiter_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // command[1:0], writer_id[5:2], zero
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // granted[0], present[1], empty_release[2], zero
);

    logic                   bypass_reg;
    logic                   advance;
    logic                   item_valid;
    fwa_pkg::item_t         in_item;
    fwa_pkg::item_t         item;
    fwa_pkg::result_t       result;
    fwa_pkg::result_t       out_result;
    fwa_pkg::queue_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            bypass_reg <= cfg_wr_data;
        end
    end

    assign in_item.command = s_axis_tdata[1:0];
    assign in_item.writer_id = s_axis_tdata[5:2];

    fwa_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    fwa_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .bypass (bypass_reg),
        .fire   (item_valid && advance),
        .item   (item),
        .result (result),
        .status (status)
    );

    fwa_out_reg u_out_reg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (item_valid),
        .load_result (result),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_result  (out_result),
        .advance     (advance)
    );

    assign m_axis_tdata = {5'b0, out_result.empty_release, out_result.present,
                           out_result.granted};

    // The bitmap holds exactly one bit per queued writer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(status.waiting_bitmap) == int'(status.entry_count))
    else $error("waiting bitmap disagrees with entry count");

    assert property (@(posedge clk) disable iff (!rst_n)
        int'(status.entry_count) <= fwa_pkg::WRITER_COUNT)
    else $error("entry count exceeds writer count");

    // A response can only appear after a request sat in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(item_valid))
    else $error("response without a pending request");

endmodule

`default_nettype wire

// ----- tb/fifo_writer_arbiter_top_tb.sv -----
// Testbench for fifo_writer_arbiter_top: directed and random arbitration traffic,
// checked against a cycle-free model of the writer queue, bitmap and bypass flag.
// Depends on fwa_pkg and the fifo_writer_arbiter_top RTL.
`timescale 1ns / 1ps

module fifo_writer_arbiter_top_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int LATENCY = 2;
    localparam int HOLD_CYCLES = 240;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ANSWER_DEPTH = 16;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    // Model of the arbiter state.
    logic [fwa_pkg::ID_W-1:0]         order_ids [fwa_pkg::WRITER_COUNT];
    logic [fwa_pkg::PTR_W-1:0]        head_idx = '0;
    logic [fwa_pkg::CNT_W-1:0]        queued = '0;
    logic [fwa_pkg::WRITER_COUNT-1:0] waiting = '0;
    logic                             bypass_on = 1'b0;

    // Expected responses in request order, kept as a ring with two counters.
    fwa_pkg::result_t expected_answers [ANSWER_DEPTH];
    int unsigned answers_stored = 0;
    int unsigned answers_checked = 0;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    fifo_writer_arbiter_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Applies one request to the queue model and returns the expected response.
    function automatic fwa_pkg::result_t arbitrate(input logic [1:0] cmd,
                                                   input logic [fwa_pkg::ID_W-1:0] id);
        fwa_pkg::result_t          answer;
        logic [fwa_pkg::PTR_W-1:0] tail;
        answer = '0;
        case (cmd)
            fwa_pkg::CMD_REQUEST:
            begin
                if (bypass_on)
                begin
                    answer.granted = 1'b1;
                end
                else
                begin
                    if (!waiting[id] && queued < fwa_pkg::WRITER_COUNT)
                    begin
                        tail = head_idx + fwa_pkg::PTR_W'(queued);
                        order_ids[tail] = id;
                        queued = queued + fwa_pkg::CNT_W'(1);
                        waiting[id] = 1'b1;
                    end
                    answer.granted = (queued != 0) && (order_ids[head_idx] == id);
                end
            end
            fwa_pkg::CMD_RELEASE:
            begin
                if (!bypass_on)
                begin
                    if (queued == 0)
                    begin
                        answer.empty_release = 1'b1;
                    end
                    else
                    begin
                        waiting[order_ids[head_idx]] = 1'b0;
                        head_idx = head_idx + fwa_pkg::PTR_W'(1);
                        queued = queued - fwa_pkg::CNT_W'(1);
                    end
                end
            end
            fwa_pkg::CMD_QUERY:
            begin
                if (!bypass_on)
                begin
                    answer.present = waiting[id];
                end
            end
            default:
            begin
            end
        endcase
        return answer;
    endfunction

    always @(posedge clk)
    begin
        fwa_pkg::result_t want;
        fwa_pkg::result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = fwa_pkg::result_t'(m_axis_tdata[2:0]);
            if (answers_stored == answers_checked)
            begin
                $error("Unexpected response 0x%02h with no request outstanding.", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_answers[answers_checked % ANSWER_DEPTH];
                answers_checked++;
                if (got.granted !== want.granted)
                begin
                    $error("granted: expected %0d, actual %0d", want.granted, got.granted);
                    mismatch_count++;
                end
                if (got.present !== want.present)
                begin
                    $error("present: expected %0d, actual %0d", want.present, got.present);
                    mismatch_count++;
                end
                if (got.empty_release !== want.empty_release)
                begin
                    $error("empty_release: expected %0d, actual %0d",
                           want.empty_release, got.empty_release);
                    mismatch_count++;
                end
            end
        end
    end

    // The receiver holds off for a long stretch whenever a test asks for it.
    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [fwa_pkg::ID_W-1:0] id);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, id, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_answers[answers_stored % ANSWER_DEPTH] = arbitrate(cmd, id);
        answers_stored++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_for_answers();
        stop_sending();
        while (answers_stored != answers_checked)
            @(posedge clk);
    endtask

    task automatic set_bypass(input logic value);
        wait_for_answers();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        bypass_on = value;
    endtask

    task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
        sender_idle_pct = sender_pct;
        receiver_idle_pct = receiver_pct;
    endtask

    // Bursts that lean toward filling, toward draining, or neither, so the
    // queue sweeps between empty and all sixteen writers waiting.
    task automatic run_random_traffic(input int unsigned count);
        int unsigned burst_left;
        int unsigned request_pct;
        int unsigned release_pct;
        int unsigned roll;
        logic [1:0]  cmd;
        burst_left = 0;
        request_pct = 40;
        release_pct = 35;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(60, 15);
                roll = $urandom_range(2);
                if (roll == 0)
                begin
                    request_pct = 70;
                    release_pct = 10;
                end
                else if (roll == 1)
                begin
                    request_pct = 15;
                    release_pct = 65;
                end
                else
                begin
                    request_pct = 40;
                    release_pct = 35;
                end
            end
            roll = $urandom_range(99);
            if (roll < 3)
                cmd = CMD_UNUSED;
            else if (roll < 3 + request_pct)
                cmd = fwa_pkg::CMD_REQUEST;
            else if (roll < 3 + request_pct + release_pct)
                cmd = fwa_pkg::CMD_RELEASE;
            else
                cmd = fwa_pkg::CMD_QUERY;
            send_request(cmd, fwa_pkg::ID_W'($urandom_range(fwa_pkg::WRITER_COUNT - 1)));
            burst_left--;
        end
    endtask

    task automatic test_directed_queue();
        set_idling(0, 0);
        send_request(fwa_pkg::CMD_RELEASE, 4'd0);
        send_request(fwa_pkg::CMD_REQUEST, 4'd0);
        send_request(fwa_pkg::CMD_REQUEST, 4'd15);
        send_request(fwa_pkg::CMD_REQUEST, 4'd0);
        send_request(fwa_pkg::CMD_REQUEST, 4'd15);
        send_request(fwa_pkg::CMD_QUERY, 4'd15);
        send_request(fwa_pkg::CMD_QUERY, 4'd5);
        send_request(CMD_UNUSED, 4'd15);
        send_request(fwa_pkg::CMD_RELEASE, 4'd0);
        send_request(fwa_pkg::CMD_REQUEST, 4'd15);
        send_request(fwa_pkg::CMD_QUERY, 4'd0);
        send_request(fwa_pkg::CMD_RELEASE, 4'd15);
        send_request(fwa_pkg::CMD_RELEASE, 4'd15);
        send_request(fwa_pkg::CMD_QUERY, 4'd15);
    endtask

    task automatic test_directed_bypass();
        send_request(fwa_pkg::CMD_REQUEST, 4'd7);
        send_request(fwa_pkg::CMD_REQUEST, 4'd9);
        set_bypass(1'b1);
        send_request(fwa_pkg::CMD_REQUEST, 4'd9);
        send_request(fwa_pkg::CMD_RELEASE, 4'd0);
        send_request(fwa_pkg::CMD_QUERY, 4'd7);
        send_request(CMD_UNUSED, 4'd10);
        set_bypass(1'b0);
        send_request(fwa_pkg::CMD_QUERY, 4'd7);
        send_request(fwa_pkg::CMD_RELEASE, 4'd0);
        send_request(fwa_pkg::CMD_RELEASE, 4'd0);
        send_request(fwa_pkg::CMD_RELEASE, 4'd0);
    endtask

    task automatic test_random_queueing();
        set_idling(26, 45);
        run_random_traffic(500);
        set_idling(45, 26);
        run_random_traffic(450);
    endtask

    task automatic test_random_bypass();
        set_bypass(1'b1);
        set_idling(26, 45);
        run_random_traffic(150);
        set_bypass(1'b0);
    endtask

    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_requests++;
        run_random_traffic(80);
    endtask

    task automatic test_unthrottled();
        set_idling(0, 0);
        set_bypass(1'b1);
        run_random_traffic(50);
        set_bypass(1'b0);
        run_random_traffic(300);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_queue();
        test_directed_bypass();
        test_random_queueing();
        test_random_bypass();
        test_output_backpressure();
        test_unthrottled();
        wait_for_answers();
        repeat (LATENCY + 8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- fifo_writer_arbiter_top.f -----
rtl/fwa_pkg.sv
rtl/fwa_in_reg.sv
rtl/fwa_queue.sv
rtl/fwa_out_reg.sv
rtl/fifo_writer_arbiter_top.sv
tb/fifo_writer_arbiter_top_tb.sv
